### rtl/core/rcfe_pkg.sv
package rcfe_pkg;

  // longest frame in characters, one cell per character
  localparam int unsigned FRAME_LEN = 14;

  // request kinds
  localparam logic [2:0] CMD_RC   = 3'd0;
  localparam logic [2:0] CMD_CAL  = 3'd1;
  localparam logic [2:0] CMD_PWON = 3'd2;
  localparam logic [2:0] CMD_HON  = 3'd3;
  localparam logic [2:0] CMD_HOFF = 3'd4;

  localparam logic [7:0] CH_SOF = 8'h3a;  // ':'
  localparam logic [7:0] CH_EOF = 8'h2f;  // '/'

  // what a cell holds: a plain character or a checksum digit slot
  typedef enum logic [1:0] {
    K_SOF  = 2'd0,
    K_DATA = 2'd1,
    K_CKH  = 2'd2,
    K_CKL  = 2'd3
  } char_kind_t;

  typedef struct packed {
    logic       valid;
    char_kind_t kind;
    logic       last;
    logic       stick;
    logic [7:0] ch;
  } cell_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] throttle;
    logic [11:0] pitch;
    logic [11:0] roll;
    logic [11:0] yaw;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       stick_frame;
  } out_word_t;

  // uppercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (8'd48 + {4'd0, nib}) : (8'd55 + {4'd0, nib});
  endfunction

  // fold a 12-bit stick sample about the centre into sign-magnitude
  function automatic logic [7:0] fold_axis(input logic [11:0] s, input logic invert);
    logic [4:0] mag;
    logic       sgn;
    if (!s[11]) begin
      mag = ~s[10:6];
      sgn = ~invert;
    end else begin
      mag = s[10:6];
      sgn = invert;
    end
    fold_axis = {sgn, 2'b00, mag};
  endfunction

endpackage

### rtl/core/rcfe_cell.sv
module rcfe_cell
  import rcfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  cell_t load_val,
  input  cell_t shift_in,
  output cell_t q
);

  cell_t cell_r;
  cell_t cell_nxt;

  // take a fresh frame character on load, else the neighbor's
  always_comb begin
    cell_nxt = load ? load_val : shift_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.kind  <= cell_nxt.kind;
    cell_r.last  <= cell_nxt.last;
    cell_r.stick <= cell_nxt.stick;
    cell_r.ch    <= cell_nxt.ch;
  end

  assign q = cell_r;

endmodule

### rtl/core/rcfe_frame.sv
module rcfe_frame
  import rcfe_pkg::*;
(
  input  in_word_t                 in_word,
  output cell_t [FRAME_LEN-1:0]    image
);

  logic [7:0] body [FRAME_LEN];
  logic [3:0] body_len;
  logic       stick;
  logic [7:0] th_b, p_b, r_b, y_b;

  assign th_b = in_word.throttle[11:4];
  assign p_b  = fold_axis(in_word.pitch, 1'b0);
  assign r_b  = fold_axis(in_word.roll, 1'b1);
  assign y_b  = fold_axis(in_word.yaw, 1'b0);

  // ':' + tag + payload characters of each request kind
  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      body[i] = 8'h00;
    end
    body[0]  = CH_SOF;
    body_len = 4'd0;
    stick    = 1'b0;
    case (in_word.cmd)
      CMD_RC: begin
        stick    = 1'b1;
        body[1]  = "R";
        body[2]  = "C";
        body[3]  = hex_digit(th_b[7:4]);
        body[4]  = hex_digit(th_b[3:0]);
        body[5]  = hex_digit(p_b[7:4]);
        body[6]  = hex_digit(p_b[3:0]);
        body[7]  = hex_digit(r_b[7:4]);
        body[8]  = hex_digit(r_b[3:0]);
        body[9]  = hex_digit(y_b[7:4]);
        body[10] = hex_digit(y_b[3:0]);
        body_len = 4'd11;
      end
      CMD_CAL: begin
        body[1] = "C"; body[2] = "A"; body[3] = "L";
        body_len = 4'd4;
      end
      CMD_PWON: begin
        body[1] = "P"; body[2] = "W"; body[3] = "O"; body[4] = "N";
        body_len = 4'd5;
      end
      CMD_HON: begin
        body[1] = "H"; body[2] = "O"; body[3] = "N";
        body_len = 4'd4;
      end
      CMD_HOFF: begin
        body[1] = "H"; body[2] = "O"; body[3] = "F"; body[4] = "F";
        body_len = 4'd5;
      end
      default: begin
        body_len = 4'd0;
      end
    endcase
  end

  // lay out body, two checksum slots and '/' over the cells
  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      image[i]       = '0;
      image[i].stick = stick;
      image[i].ch    = body[i];
      if (body_len != 4'd0) begin
        if (4'(i) < body_len) begin
          image[i].valid = 1'b1;
          image[i].kind  = (i == 0) ? K_SOF : K_DATA;
        end else if (4'(i) == body_len) begin
          image[i].valid = 1'b1;
          image[i].kind  = K_CKH;
        end else if (4'(i) == body_len + 4'd1) begin
          image[i].valid = 1'b1;
          image[i].kind  = K_CKL;
        end else if (4'(i) == body_len + 4'd2) begin
          image[i].valid = 1'b1;
          image[i].kind  = K_DATA;
          image[i].last  = 1'b1;
          image[i].ch    = CH_EOF;
        end
      end
    end
  end

endmodule

### rtl/core/rcfe_out.sv
module rcfe_out
  import rcfe_pkg::*;
(
  input  logic      clk,
  input  cell_t     head,
  output logic      out_valid,
  output out_word_t out_word
);

  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] ck;

  // running byte sum of the characters leaving the chain
  always_comb begin
    sum_nxt = sum_r;
    if (head.valid) begin
      case (head.kind)
        K_SOF:   sum_nxt = 8'd0;
        K_DATA:  sum_nxt = sum_r + head.ch;
        default: sum_nxt = sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign ck = 8'd0 - sum_r;

  // checksum slots turn into hex digits as they reach the head
  always_comb begin
    out_valid            = head.valid;
    out_word.last        = head.last;
    out_word.stick_frame = head.stick;
    case (head.kind)
      K_CKH:   out_word.frame_byte = hex_digit(ck[7:4]);
      K_CKL:   out_word.frame_byte = hex_digit(ck[3:0]);
      default: out_word.frame_byte = head.ch;
    endcase
  end

endmodule

### rtl/core/remote_command_frame_encoder_core.sv
// The first character (':') is on the output in the cycle after start is taken.
// Throughput: one character per cycle; a frame of N characters (RC 14, CAL/HON 7,
// PWON/HOFF 8) holds busy until only its last character is left in the 14-cell chain,
// so frames follow back to back. An undefined request kind is taken and gives no word.
// Reset empties the chain; no word is shown until the next start. The receiver
// cannot stall: each word is on out_word for exactly one cycle with out_valid.
module remote_command_frame_encoder_core
  import rcfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_word
);

  cell_t [FRAME_LEN-1:0] image;
  cell_t [FRAME_LEN-1:0] chain;
  logic                  load;

  rcfe_frame u_frame (
    .in_word (in_word),
    .image   (image)
  );

  // a new frame may load once only the head character remains
  assign busy = chain[1].valid;
  assign load = start && !busy;

  // character chain, shifting toward the head in every cycle without a load
  for (genvar i = 0; i < FRAME_LEN; i++) begin : g_chain
    cell_t shift_in;
    if (i == FRAME_LEN - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = chain[i+1];
    end
    rcfe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .load_val (image[i]),
      .shift_in (shift_in),
      .q        (chain[i])
    );
  end

  rcfe_out u_out (
    .clk       (clk),
    .head      (chain[0]),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
